>>> design/dop_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option parser package
// Widths, option codes, length rules and result status codes shared by the
// parser, its channel interfaces, the checker and the testbench.
// ----------------------------------------------------------------------------
package dop_pkg;

   localparam int BYTE_W   = 8;
   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int STATUS_W = 2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 2'd2;

   // Option codes.
   localparam logic [BYTE_W-1:0] CODE_PAD      = 8'd0;
   localparam logic [BYTE_W-1:0] CODE_REQIP    = 8'd50;
   localparam logic [BYTE_W-1:0] CODE_MSGTYPE  = 8'd53;
   localparam logic [BYTE_W-1:0] CODE_CLIENTID = 8'd61;
   localparam logic [BYTE_W-1:0] CODE_END      = 8'd255;

   // Required option lengths.
   localparam logic [BYTE_W-1:0] MSGTYPE_LEN  = 8'd1;
   localparam logic [BYTE_W-1:0] REQIP_LEN    = 8'd4;
   localparam logic [BYTE_W-1:0] CID_MIN_LEN  = 8'd2;
   localparam logic [BYTE_W-1:0] CID_ETH_LEN  = 8'd7;

   // Client identifier hardware type for Ethernet.
   localparam logic [BYTE_W-1:0] HWTYPE_ETHERNET = 8'd1;

   // Message types that the server answers.
   localparam logic [BYTE_W-1:0] MSG_DISCOVER = 8'd1;
   localparam logic [BYTE_W-1:0] MSG_REQUEST  = 8'd3;

endpackage

>>> design/dop_if.sv
// ----------------------------------------------------------------------------
// DHCP option parser channel interfaces
// Valid/ready channels for option bytes in and packet results out.
// ----------------------------------------------------------------------------
interface dop_req_if;
   logic                         valid;
   logic                         ready;
   logic [dop_pkg::BYTE_W-1:0]   opt_byte;
   logic                         last_byte;
   logic [dop_pkg::IP_W-1:0]     hdr_client_ip;
   logic [dop_pkg::MAC_W-1:0]    hdr_client_mac;

   modport source (output valid, opt_byte, last_byte, hdr_client_ip, hdr_client_mac,
                   input ready);
   modport sink   (input valid, opt_byte, last_byte, hdr_client_ip, hdr_client_mac,
                   output ready);
endinterface

interface dop_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dop_pkg::STATUS_W-1:0] status;
   logic [dop_pkg::BYTE_W-1:0]   msg_type;
   logic                         client_id_seen;
   logic [dop_pkg::MAC_W-1:0]    client_mac;
   logic [dop_pkg::IP_W-1:0]     preferred_ip;
   logic                         serve;

   modport source (output valid, status, msg_type, client_id_seen, client_mac,
                   preferred_ip, serve, input ready);
   modport sink   (input valid, status, msg_type, client_id_seen, client_mac,
                   preferred_ip, serve, output ready);
endinterface

>>> design/dhcp_option_parser.sv
// ----------------------------------------------------------------------------
// DHCP option parser
// Walks the option area of a DHCP packet one byte per item and reports the
// message type, client MAC and preferred IP once per packet.
// ----------------------------------------------------------------------------
// The parser takes one option byte per clock cycle while its input is not
// held off as described below. The parse state is updated on the
// cycle a byte is accepted, and the packet's result is loaded into a single
// output register at the edge that accepts the byte marked last, so it is
// presented on the following cycle. Bytes keep flowing while that result
// waits; only when the output register is full and not being taken is the
// input held off. Bytes after the End option, or after an option with a bad
// length, are consumed without effect up to the last byte of the packet.
module dhcp_option_parser (
   input logic clock,
   input logic reset,
   dop_req_if.sink   req_ch,
   dop_rsp_if.source rsp_ch
);
   import dop_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_CODE,
      PH_LEN,
      PH_DATA,
      PH_DONE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [BYTE_W-1:0]      cur_code_ff, cur_code_in;
   logic [BYTE_W-1:0]      opt_length_ff, opt_length_in;
   logic [BYTE_W-1:0]      bytes_left_ff, bytes_left_in;
   logic [STATUS_W-1:0]    pend_status_ff, pend_status_in;
   logic                   bad_len_ff, bad_len_in;
   logic [BYTE_W-1:0]      msg_type_ff, msg_type_in;
   logic                   id_seen_ff, id_seen_in;
   logic                   id_eth_ff, id_eth_in;
   logic [MAC_W-1:0]       mac_ff, mac_in;
   logic [IP_W-1:0]        ip_ff, ip_in;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]      rsp_msg_type_ff, rsp_msg_type_in;
   logic                   rsp_id_seen_ff, rsp_id_seen_in;
   logic [MAC_W-1:0]       rsp_mac_ff, rsp_mac_in;
   logic [IP_W-1:0]        rsp_ip_ff, rsp_ip_in;
   logic                   rsp_serve_ff, rsp_serve_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [BYTE_W-1:0]      b;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   assign b            = req_ch.opt_byte;

   // Per-byte parse step. Blocking updates mirror the order of the option walk.
   always_comb begin
      phase_in       = phase_ff;
      cur_code_in    = cur_code_ff;
      opt_length_in  = opt_length_ff;
      bytes_left_in  = bytes_left_ff;
      pend_status_in = pend_status_ff;
      bad_len_in     = bad_len_ff;
      msg_type_in    = msg_type_ff;
      id_seen_in     = id_seen_ff;
      id_eth_in      = id_eth_ff;
      mac_in         = mac_ff;
      ip_in          = ip_ff;

      // The first byte of a packet loads the header defaults.
      if (phase_ff == PH_START) begin
         ip_in          = req_ch.hdr_client_ip;
         mac_in         = req_ch.hdr_client_mac;
         msg_type_in    = '0;
         id_seen_in     = 1'b0;
         id_eth_in      = 1'b0;
         bad_len_in     = 1'b0;
         pend_status_in = STATUS_OK;
      end

      unique case (phase_ff)
         PH_START, PH_CODE: begin
            if (b == CODE_PAD) begin
               phase_in = PH_CODE;
            end else if (b == CODE_END) begin
               pend_status_in = STATUS_OK;
               phase_in       = PH_DONE;
            end else begin
               cur_code_in = b;
               phase_in    = PH_LEN;
            end
         end
         PH_LEN: begin
            opt_length_in = b;
            bytes_left_in = b;
            id_eth_in     = 1'b0;
            if (cur_code_ff == CODE_MSGTYPE) begin
               bad_len_in = (b != MSGTYPE_LEN);
            end else if (cur_code_ff == CODE_CLIENTID) begin
               bad_len_in = (b < CID_MIN_LEN);
            end else if (cur_code_ff == CODE_REQIP) begin
               bad_len_in = (b != REQIP_LEN);
            end else begin
               bad_len_in = 1'b0;
            end
            if (b == '0) begin
               if (bad_len_in) begin
                  pend_status_in = STATUS_BAD_LEN;
                  phase_in       = PH_DONE;
               end else begin
                  phase_in = PH_CODE;
               end
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!bad_len_ff) begin
               if (cur_code_ff == CODE_MSGTYPE) begin
                  msg_type_in = b;
               end else if (cur_code_ff == CODE_CLIENTID) begin
                  // The first content byte is the hardware type.
                  if (bytes_left_ff == opt_length_ff) begin
                     id_eth_in = (b == HWTYPE_ETHERNET);
                     if (b == HWTYPE_ETHERNET && opt_length_ff != CID_ETH_LEN) begin
                        bad_len_in = 1'b1;
                     end
                  end else if (id_eth_ff) begin
                     mac_in = {mac_ff[MAC_W-BYTE_W-1:0], b};
                  end
               end else if (cur_code_ff == CODE_REQIP) begin
                  ip_in = {ip_ff[IP_W-BYTE_W-1:0], b};
               end
            end
            bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == '0) begin
               if (bad_len_in) begin
                  pend_status_in = STATUS_BAD_LEN;
                  phase_in       = PH_DONE;
               end else begin
                  if (cur_code_ff == CODE_CLIENTID && id_eth_in) begin
                     id_seen_in = 1'b1;
                  end
                  phase_in = PH_CODE;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // Result for the packet, used only when this byte is the last one.
      rsp_status_in = (phase_in == PH_DONE) ? pend_status_in : STATUS_MALFORMED;
      if (rsp_status_in == STATUS_OK) begin
         rsp_msg_type_in = msg_type_in;
         rsp_id_seen_in  = id_seen_in;
         rsp_mac_in      = mac_in;
         rsp_ip_in       = ip_in;
         rsp_serve_in    = (msg_type_in == MSG_DISCOVER) || (msg_type_in == MSG_REQUEST);
      end else begin
         rsp_msg_type_in = '0;
         rsp_id_seen_in  = 1'b0;
         rsp_mac_in      = '0;
         rsp_ip_in       = '0;
         rsp_serve_in    = 1'b0;
      end

      if (req_ch.last_byte) begin
         phase_in      = PH_START;
         cur_code_in   = '0;
         opt_length_in = '0;
         bytes_left_in = '0;
         bad_len_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff       <= phase_in;
            cur_code_ff    <= cur_code_in;
            opt_length_ff  <= opt_length_in;
            bytes_left_ff  <= bytes_left_in;
            pend_status_ff <= pend_status_in;
            bad_len_ff     <= bad_len_in;
            msg_type_ff    <= msg_type_in;
            id_seen_ff     <= id_seen_in;
            id_eth_ff      <= id_eth_in;
            mac_ff         <= mac_in;
            ip_ff          <= ip_in;
         end
         if (req_fire && req_ch.last_byte) begin
            rsp_valid_ff    <= 1'b1;
            rsp_status_ff   <= rsp_status_in;
            rsp_msg_type_ff <= rsp_msg_type_in;
            rsp_id_seen_ff  <= rsp_id_seen_in;
            rsp_mac_ff      <= rsp_mac_in;
            rsp_ip_ff       <= rsp_ip_in;
            rsp_serve_ff    <= rsp_serve_in;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.msg_type       = rsp_msg_type_ff;
   assign rsp_ch.client_id_seen = rsp_id_seen_ff;
   assign rsp_ch.client_mac     = rsp_mac_ff;
   assign rsp_ch.preferred_ip   = rsp_ip_ff;
   assign rsp_ch.serve          = rsp_serve_ff;

   // A last byte always leaves a result behind and rearms the packet start.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.last_byte) |=> (rsp_ch.valid && phase_ff == PH_START))
      else $error("last byte did not produce a result or rearm the parser");

   // A rejected packet reports no fields.
   a_reject_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |->
      (rsp_ch.msg_type == '0 && !rsp_ch.client_id_seen && rsp_ch.client_mac == '0 &&
       rsp_ch.preferred_ip == '0 && !rsp_ch.serve))
      else $error("rejected packet carries field values");

   // Serve only for an accepted Discover or Request.
   a_serve_rule: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.serve) |->
      (rsp_ch.status == STATUS_OK &&
       (rsp_ch.msg_type == MSG_DISCOVER || rsp_ch.msg_type == MSG_REQUEST)))
      else $error("serve flag set for a packet that should not be served");

   // Inside an option's content there is always at least one byte left.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_left_ff != '0))
      else $error("option content phase with no bytes left");

endmodule

>>> sim/dhcp_option_checker.sv
// ----------------------------------------------------------------------------
// DHCP option parser checker
// Watches both channels of the parser, works out each packet's result from the
// option bytes it accepts, and compares every result item field by field.
// ----------------------------------------------------------------------------
module dhcp_option_checker (
   input  logic        clock,
   input  logic        reset,
   dop_req_if          req_ch,
   dop_rsp_if          rsp_ch,
   output int unsigned error_count,
   output int unsigned results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import dop_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_CODE,
      PH_LEN,
      PH_DATA,
      PH_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   msg_type;
      logic                client_id_seen;
      logic [MAC_W-1:0]    client_mac;
      logic [IP_W-1:0]     preferred_ip;
      logic                serve;
   } packet_result_type;

   packet_result_type   packet_results[$];

   parse_phase_type     parse_phase;
   logic [BYTE_W-1:0]   option_code;
   logic [BYTE_W-1:0]   option_len;
   logic [BYTE_W-1:0]   option_left;
   logic [STATUS_W-1:0] status_so_far;
   logic                length_fault;
   logic [BYTE_W-1:0]   msg_type_seen;
   logic                cid_valid;
   logic                cid_ethernet;
   logic [MAC_W-1:0]    mac_accum;
   logic [IP_W-1:0]     ip_accum;

   task automatic report_error(input string msg);
      if (error_count < 50) begin
         $display("ERROR at %0t ns: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic clear_parse_state();
      parse_phase   = PH_START;
      option_code   = '0;
      option_len    = '0;
      option_left   = '0;
      status_so_far = STATUS_OK;
      length_fault  = 1'b0;
      msg_type_seen = '0;
      cid_valid     = 1'b0;
      cid_ethernet  = 1'b0;
      mac_accum     = '0;
      ip_accum      = '0;
   endtask

   // A completed option either commits a client identifier or, if its length
   // was wrong, ends parsing with a bad-length status.
   task automatic close_option();
      if (length_fault) begin
         status_so_far = STATUS_BAD_LEN;
         parse_phase   = PH_DONE;
      end else begin
         if (option_code == CODE_CLIENTID && cid_ethernet) begin
            cid_valid = 1'b1;
         end
         parse_phase = PH_CODE;
      end
   endtask

   task automatic absorb_option_byte(input logic [BYTE_W-1:0] b, input logic last,
                                     input logic [IP_W-1:0] hdr_ip,
                                     input logic [MAC_W-1:0] hdr_mac);
      logic [BYTE_W-1:0] idx;
      packet_result_type res;
      if (parse_phase == PH_START) begin
         ip_accum      = hdr_ip;
         mac_accum     = hdr_mac;
         msg_type_seen = '0;
         cid_valid     = 1'b0;
         cid_ethernet  = 1'b0;
         length_fault  = 1'b0;
         status_so_far = STATUS_OK;
      end
      case (parse_phase)
         PH_START, PH_CODE: begin
            if (b == CODE_PAD) begin
               parse_phase = PH_CODE;
            end else if (b == CODE_END) begin
               status_so_far = STATUS_OK;
               parse_phase   = PH_DONE;
            end else begin
               option_code = b;
               parse_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            option_len   = b;
            option_left  = b;
            cid_ethernet = 1'b0;
            if (option_code == CODE_MSGTYPE) begin
               length_fault = (b != MSGTYPE_LEN);
            end else if (option_code == CODE_CLIENTID) begin
               length_fault = (b < CID_MIN_LEN);
            end else if (option_code == CODE_REQIP) begin
               length_fault = (b != REQIP_LEN);
            end else begin
               length_fault = 1'b0;
            end
            if (b == 0) begin
               close_option();
            end else begin
               parse_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            idx = option_len - option_left;
            if (!length_fault) begin
               if (option_code == CODE_MSGTYPE) begin
                  msg_type_seen = b;
               end else if (option_code == CODE_CLIENTID) begin
                  if (idx == 0) begin
                     cid_ethernet = (b == HWTYPE_ETHERNET);
                     if (b == HWTYPE_ETHERNET && option_len != CID_ETH_LEN) begin
                        length_fault = 1'b1;
                     end
                  end else if (cid_ethernet) begin
                     mac_accum = {mac_accum[MAC_W-BYTE_W-1:0], b};
                  end
               end else if (option_code == CODE_REQIP) begin
                  ip_accum = {ip_accum[IP_W-BYTE_W-1:0], b};
               end
            end
            option_left = option_left - 8'd1;
            if (option_left == 0) begin
               close_option();
            end
         end
         default: begin
         end
      endcase

      if (last) begin
         res        = '0;
         res.status = (parse_phase == PH_DONE) ? status_so_far : STATUS_MALFORMED;
         if (res.status == STATUS_OK) begin
            res.msg_type       = msg_type_seen;
            res.client_id_seen = cid_valid;
            res.client_mac     = mac_accum;
            res.preferred_ip   = ip_accum;
            res.serve          = (msg_type_seen == MSG_DISCOVER) ||
                                 (msg_type_seen == MSG_REQUEST);
         end
         packet_results.push_back(res);
         parse_phase  = PH_START;
         option_code  = '0;
         option_len   = '0;
         option_left  = '0;
         length_fault = 1'b0;
      end
   endtask

   task automatic check_result();
      packet_result_type want;
      if (packet_results.size() == 0) begin
         report_error("result item arrived with no packet outstanding");
      end else begin
         want = packet_results.pop_front();
         if (rsp_ch.status !== want.status) begin
            report_error($sformatf("status: got %0d, expected %0d",
                                   rsp_ch.status, want.status));
         end
         if (rsp_ch.msg_type !== want.msg_type) begin
            report_error($sformatf("msg_type: got %0d, expected %0d",
                                   rsp_ch.msg_type, want.msg_type));
         end
         if (rsp_ch.client_id_seen !== want.client_id_seen) begin
            report_error($sformatf("client_id_seen: got %0b, expected %0b",
                                   rsp_ch.client_id_seen, want.client_id_seen));
         end
         if (rsp_ch.client_mac !== want.client_mac) begin
            report_error($sformatf("client_mac: got %012h, expected %012h",
                                   rsp_ch.client_mac, want.client_mac));
         end
         if (rsp_ch.preferred_ip !== want.preferred_ip) begin
            report_error($sformatf("preferred_ip: got %08h, expected %08h",
                                   rsp_ch.preferred_ip, want.preferred_ip));
         end
         if (rsp_ch.serve !== want.serve) begin
            report_error($sformatf("serve: got %0b, expected %0b",
                                   rsp_ch.serve, want.serve));
         end
      end
   endtask

   // Results are checked before the byte of the same edge is absorbed, since a
   // result never leaves the parser on the edge that accepts its last byte.
   always @(posedge clock) begin
      if (reset) begin
         clear_parse_state();
         packet_results.delete();
         results_outstanding <= 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_result();
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            absorb_option_byte(req_ch.opt_byte, req_ch.last_byte,
                               req_ch.hdr_client_ip, req_ch.hdr_client_mac);
         end
         results_outstanding <= packet_results.size();
      end
   end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// DHCP option parser testbench
// Feeds option areas byte by byte (directed packets, then random well-formed,
// broken and noise packets) under varying sender and receiver stalls, and
// gives the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dop_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned RANDOM_BYTES = 1800;
   localparam int unsigned HOLD_CYCLES  = 400;

   typedef logic [BYTE_W-1:0] option_bytes_type[$];

   logic        clock = 1'b0;
   logic        reset;
   int unsigned error_count;
   int unsigned results_outstanding;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned cycle_count  = 0;
   bit          hold_request = 1'b0;

   dop_req_if req_ch();
   dop_rsp_if rsp_ch();

   dhcp_option_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dhcp_option_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_ch              (req_ch),
      .rsp_ch              (rsp_ch),
      .error_count         (error_count),
      .results_outstanding (results_outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input logic [IP_W-1:0] hdr_ip, input logic [MAC_W-1:0] hdr_mac);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.opt_byte       <= b;
      req_ch.last_byte      <= last;
      req_ch.hdr_client_ip  <= hdr_ip;
      req_ch.hdr_client_mac <= hdr_mac;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Header fields only matter on the first byte; later bytes carry noise there.
   task automatic send_packet(input option_bytes_type pkt, input logic [IP_W-1:0] hdr_ip,
                              input logic [MAC_W-1:0] hdr_mac);
      logic [63:0] noise;
      for (int i = 0; i < pkt.size(); i++) begin
         noise = {$urandom, $urandom};
         if (i == 0) begin
            send_byte(pkt[i], pkt.size() == 1, hdr_ip, hdr_mac);
         end else begin
            send_byte(pkt[i], i == pkt.size() - 1, $urandom, noise[MAC_W-1:0]);
         end
      end
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
   endtask

   task automatic make_packet(output option_bytes_type pkt);
      int unsigned kind;
      int unsigned n_opts;
      int unsigned bad_at;
      int unsigned pick;
      int unsigned len;
      logic [BYTE_W-1:0] code;
      pkt  = {};
      kind = $urandom_range(99);
      if (kind >= 92) begin
         repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      end else begin
         n_opts = $urandom_range(0, 5);
         bad_at = (kind >= 72) ? $urandom_range(0, n_opts) : n_opts + 1;
         for (int i = 0; i <= n_opts; i++) begin
            if (i == bad_at) begin
               pick = $urandom_range(3);
               case (pick)
                  0: begin
                     len  = $urandom_range(0, 3);
                     if (len == 1) len = ($urandom_range(9) == 0) ? 255 : 0;
                     code = CODE_MSGTYPE;
                  end
                  1: begin
                     len  = $urandom_range(0, 1);
                     code = CODE_CLIENTID;
                  end
                  2: begin
                     len = $urandom_range(2, 11);
                     if (len == 7) len = 12;
                     code = CODE_CLIENTID;
                  end
                  default: begin
                     len = $urandom_range(0, 8);
                     if (len == 4) len = 5;
                     code = CODE_REQIP;
                  end
               endcase
               pkt.push_back(code);
               pkt.push_back(8'(len));
               // An Ethernet identifier with the wrong length.
               if (pick == 2) begin
                  pkt.push_back(HWTYPE_ETHERNET);
                  len = len - 1;
               end
               repeat (len) pkt.push_back(8'($urandom));
            end
            if (i < n_opts) begin
               pick = $urandom_range(5);
               case (pick)
                  0: repeat ($urandom_range(1, 3)) pkt.push_back(CODE_PAD);
                  1: begin
                     pkt.push_back(CODE_MSGTYPE);
                     pkt.push_back(MSGTYPE_LEN);
                     pick = $urandom_range(9);
                     pkt.push_back(pick < 4 ? MSG_DISCOVER :
                                   pick < 7 ? MSG_REQUEST : 8'($urandom));
                  end
                  2: begin
                     pkt.push_back(CODE_CLIENTID);
                     pkt.push_back(CID_ETH_LEN);
                     pkt.push_back(HWTYPE_ETHERNET);
                     repeat (6) pkt.push_back(8'($urandom));
                  end
                  3: begin
                     len  = $urandom_range(2, 9);
                     code = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(2, 255));
                     pkt.push_back(CODE_CLIENTID);
                     pkt.push_back(8'(len));
                     pkt.push_back(code);
                     repeat (len - 1) pkt.push_back(8'($urandom));
                  end
                  4: begin
                     pkt.push_back(CODE_REQIP);
                     pkt.push_back(REQIP_LEN);
                     repeat (4) pkt.push_back(8'($urandom));
                  end
                  default: begin
                     code = 8'($urandom_range(1, 254));
                     if (code == CODE_REQIP || code == CODE_MSGTYPE ||
                         code == CODE_CLIENTID) begin
                        code = 8'd77;
                     end
                     len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(0, 6);
                     pkt.push_back(code);
                     pkt.push_back(8'(len));
                     repeat (len) pkt.push_back(8'($urandom));
                  end
               endcase
            end
         end
         if ($urandom_range(99) >= 6) begin
            pkt.push_back(CODE_END);
         end
         repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
         if ($urandom_range(99) < 10 && pkt.size() > 1) begin
            len = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > len) void'(pkt.pop_back());
         end
         // The parser is never handed an empty option area.
         if (pkt.size() == 0) begin
            pkt.push_back(CODE_END);
         end
      end
   endtask

   initial begin
      option_bytes_type pkt;
      int unsigned      sent;
      int unsigned      pick;
      logic [31:0]      ip;
      logic [63:0]      mac_bits;
      bit               held;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.opt_byte       <= '0;
      req_ch.last_byte      <= 1'b0;
      req_ch.hdr_client_ip  <= '0;
      req_ch.hdr_client_mac <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // End alone: accepted, header values pass through.
      pkt = {CODE_END};
      send_packet(pkt, '1, '1);
      // Pad, Request, End, then a byte that must be ignored.
      pkt = {CODE_PAD, CODE_MSGTYPE, MSGTYPE_LEN, MSG_REQUEST, CODE_END, 8'hAA};
      send_packet(pkt, '0, '0);
      // Message type with a bad length.
      pkt = {CODE_MSGTYPE, 8'd2, MSG_DISCOVER, MSG_DISCOVER, CODE_END};
      send_packet(pkt, 32'h0A000001, 48'h0000_1111_2222);
      // Requested IP cut short, and a packet of one non-End byte.
      pkt = {CODE_REQIP, REQIP_LEN, 8'd10};
      send_packet(pkt, 32'hFFFF0000, 48'hFFFF_0000_FFFF);
      pkt = {CODE_MSGTYPE};
      send_packet(pkt, '1, '0);
      pkt = {CODE_CLIENTID, CID_ETH_LEN, HWTYPE_ETHERNET, 8'h02, 8'h00, 8'h5E,
             8'hFF, 8'h00, 8'h01, CODE_END};
      send_packet(pkt, 32'hC0A80001, 48'hAAAA_BBBB_CCCC);
      pkt = {CODE_REQIP, REQIP_LEN, 8'hC0, 8'hA8, 8'h01, 8'hFE, CODE_END};
      send_packet(pkt, 32'h7F000001, '1);
      wait_for_results();

      held = 1'b0;
      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 85 : 0;
         rsp_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 6 : 0;
         sent = 0;
         while (sent < RANDOM_BYTES / 3) begin
            make_packet(pkt);
            pick     = $urandom_range(19);
            ip       = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            mac_bits = (pick == 2) ? '0 : (pick == 3) ? '1 : {$urandom, $urandom};
            send_packet(pkt, ip, mac_bits[MAC_W-1:0]);
            sent += pkt.size();
            // With no sender idling, a long receiver hold-off backs up the input.
            if (mode == 2 && !held && sent > 200) begin
               hold_request = 1'b1;
               held         = 1'b1;
            end
         end
         wait_for_results();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
